FILE: rtl/gaie_pkg.sv
// Package for the growable array block: field widths, command and result codes.
// Used by the channel interfaces and by growable_array_insert_erase.
package gaie_pkg;

	localparam int CMD_W    = 3;
	localparam int POS_W    = 10;
	localparam int VALUE_W  = 64;
	localparam int AMOUNT_W = 11;
	localparam int KIND_W   = 2;

	localparam int DEPTH_DEFAULT = 1024;

	localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_GET      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SIZE     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CAPACITY = 3'd5;

	localparam logic [KIND_W-1:0] KIND_ELEMENT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SIZE     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CAPACITY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

endpackage

FILE: rtl/gaie_if.sv
// Valid/ready channel interfaces for the command and result streams.
// Depends on gaie_pkg for the field widths.
interface gaie_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [gaie_pkg::CMD_W-1:0]          cmd;
	logic [gaie_pkg::POS_W-1:0]          position;
	logic signed [gaie_pkg::VALUE_W-1:0] value;
	logic [gaie_pkg::AMOUNT_W-1:0]       amount;
	logic                                run_last;

	modport source (output valid, cmd, position, value, amount, run_last, input ready);
	modport sink (input valid, cmd, position, value, amount, run_last, output ready);
endinterface

interface gaie_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [gaie_pkg::KIND_W-1:0]         result_kind;
	logic signed [gaie_pkg::VALUE_W-1:0] result_value;

	modport source (output valid, result_kind, result_value, input ready);
	modport sink (input valid, result_kind, result_value, output ready);
endinterface

FILE: rtl/growable_array_insert_erase.sv
// Growable ordered array of signed 64-bit values with insert, erase, set and get.
// Depends on gaie_pkg and on the channel interfaces in gaie_if.sv.
//
// Usage: commands arrive on the req channel, one per transaction; results leave on
// the rsp channel, at most one per command. Insert, erase and set give no result,
// except an insert that would fill the store, which answers with an overflow kind.
// Size and capacity each give one result; get gives one for a position in range.
// Timing: insert and erase move entries one per cycle through a single shared
// address/count unit and the one read and one write port of the element memory.
// An insert or erase keeps req.ready low after its transaction until its entries
// have moved and its last write has landed, so no new command is taken before it
// is through. Set writes when it is taken; get, size and capacity pass an emit
// state that loads the output register. A finished result sits in an output
// register, so the next command is taken while it waits; only a second result
// stalls the sequencer until the receiver takes the first one.
// Reset: arst_n clears the size to zero, the capacity to one and any open insert
// run. The memory is not cleared; an entry is only read after it was written.
module growable_array_insert_erase #(
	parameter int DEPTH = gaie_pkg::DEPTH_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	gaie_cmd_if.sink   req,
	gaie_rsp_if.source rsp
);

	// Address width; the size never exceeds DEPTH - 1, so it fits here too.
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// The capacity reaches the next power of two above the size.
	localparam int CW = AW + 1;
	// Width for comparing positions, amounts and sizes without overflow.
	localparam int XW = ((AW > gaie_pkg::POS_W) ? AW : gaie_pkg::POS_W) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [AW-1:0] fill_q;
	logic [CW-1:0] cap_q;
	logic [AW-1:0] run_offset_q;
	logic          run_active_q;
	logic          run_valid_q;

	// Shift sequencer.
	logic [AW-1:0]               src_q;
	logic [AW-1:0]               dst_q;
	logic [AW-1:0]               cnt_q;
	logic                        up_q;
	logic                        is_ins_q;
	logic [AW-1:0]               at_q;
	logic [gaie_pkg::VALUE_W-1:0] val_q;
	logic                        wpend_s1;
	logic [AW-1:0]               waddr_s1;

	// Pending result and output register.
	logic [gaie_pkg::KIND_W-1:0]  res_kind_q;
	logic [CW-1:0]                res_val_q;
	logic                         out_valid_q;
	logic [gaie_pkg::KIND_W-1:0]  out_kind_q;
	logic [gaie_pkg::VALUE_W-1:0] out_value_q;

	// Element memory.
	logic [gaie_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [gaie_pkg::VALUE_W-1:0] rd_data_q;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [gaie_pkg::VALUE_W-1:0] wr_data;

	// Decode of the incoming command.
	logic          accept;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] fill_x;
	logic [XW-1:0] amt_x;
	logic [XW-1:0] at_x;
	logic [XW-1:0] rem_x;
	logic          pos_ok;
	logic          run_start;
	logic          ins_valid;
	logic          ins_full;
	logic          ins_keep;
	logic          ins_moves;
	logic          erase_part;
	logic [CW-1:0] fill_inc;
	logic          out_free;
	logic          emit_now;
	logic          shift_done;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	assign pos_x  = XW'(req.position);
	assign fill_x = XW'(fill_q);
	assign amt_x  = XW'(req.amount);
	assign pos_ok = pos_x < fill_x;

	// Each value of a run lands one place after the previous one of the run.
	assign run_start = !run_active_q;
	assign at_x      = pos_x + (run_start ? XW'(0) : XW'(run_offset_q));
	assign ins_valid = run_start ? (pos_x <= fill_x) : run_valid_q;
	assign fill_inc  = CW'(fill_q) + CW'(1);
	assign ins_full  = fill_inc >= CW'(DEPTH);
	assign ins_moves = at_x < fill_x;
	// The run stays valid only after a stored value that is not its last.
	assign ins_keep  = ins_valid && !ins_full && !req.run_last;

	// Entries left behind the erase point; an erase never reaches past the end.
	assign rem_x      = fill_x - pos_x;
	assign erase_part = amt_x < rem_x;

	assign out_free   = !out_valid_q || rsp.ready;
	assign emit_now   = (state_q == ST_EMIT) && out_free;
	assign shift_done = (cnt_q == '0) && !wpend_s1;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = src_q;
		if (state_q == ST_SHIFT && cnt_q != '0) begin
			rd_en = 1'b1;
		end else if (accept && req.cmd == gaie_pkg::CMD_GET && pos_ok) begin
			rd_en   = 1'b1;
			rd_addr = AW'(req.position);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = waddr_s1;
		wr_data = rd_data_q;
		if (wpend_s1) begin
			wr_en = 1'b1;
		end else if (state_q == ST_SHIFT && is_ins_q && cnt_q == '0) begin
			wr_en   = 1'b1;
			wr_addr = at_q;
			wr_data = val_q;
		end else if (accept && req.cmd == gaie_pkg::CMD_SET && pos_ok) begin
			wr_en   = 1'b1;
			wr_addr = AW'(req.position);
			wr_data = req.value;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			cap_q        <= CW'(1);
			run_offset_q <= '0;
			run_active_q <= 1'b0;
			run_valid_q  <= 1'b0;
			src_q        <= '0;
			dst_q        <= '0;
			cnt_q        <= '0;
			up_q         <= 1'b0;
			is_ins_q     <= 1'b0;
			at_q         <= '0;
			val_q        <= '0;
			wpend_s1     <= 1'b0;
			waddr_s1     <= '0;
			res_kind_q   <= gaie_pkg::KIND_ELEMENT;
			res_val_q    <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= gaie_pkg::KIND_ELEMENT;
			out_value_q  <= '0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			// One entry read per cycle; its write lands in the cycle after.
			wpend_s1 <= (state_q == ST_SHIFT) && (cnt_q != '0);

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.cmd == gaie_pkg::CMD_INSERT) begin
							run_active_q <= !req.run_last;
							run_valid_q  <= ins_keep;
							run_offset_q <= ins_keep ? AW'(at_x - pos_x) + AW'(1) : '0;
							if (ins_valid && ins_full) begin
								res_kind_q <= gaie_pkg::KIND_OVERFLOW;
								res_val_q  <= '0;
								state_q    <= ST_EMIT;
							end else if (ins_valid) begin
								fill_q   <= AW'(fill_inc);
								cap_q    <= (cap_q <= fill_inc) ? (cap_q << 1) : cap_q;
								is_ins_q <= 1'b1;
								up_q     <= 1'b0;
								at_q     <= AW'(at_x);
								val_q    <= req.value;
								src_q    <= fill_q - AW'(1);
								dst_q    <= fill_q;
								cnt_q    <= ins_moves ? AW'(fill_x - at_x) : '0;
								state_q  <= ST_SHIFT;
							end
						end else begin
							run_active_q <= 1'b0;
							run_valid_q  <= 1'b0;
							run_offset_q <= '0;
							unique case (req.cmd)
								gaie_pkg::CMD_ERASE: begin
									if (pos_ok) begin
										is_ins_q <= 1'b0;
										up_q     <= 1'b1;
										src_q    <= AW'(pos_x + amt_x);
										dst_q    <= AW'(req.position);
										cnt_q    <= erase_part ? AW'(rem_x - amt_x) : '0;
										fill_q   <= erase_part ? AW'(fill_x - amt_x)
										                       : AW'(req.position);
										state_q  <= ST_SHIFT;
									end
								end
								gaie_pkg::CMD_GET: begin
									if (pos_ok) begin
										res_kind_q <= gaie_pkg::KIND_ELEMENT;
										state_q    <= ST_EMIT;
									end
								end
								gaie_pkg::CMD_SIZE: begin
									res_kind_q <= gaie_pkg::KIND_SIZE;
									res_val_q  <= CW'(fill_q);
									state_q    <= ST_EMIT;
								end
								gaie_pkg::CMD_CAPACITY: begin
									res_kind_q <= gaie_pkg::KIND_CAPACITY;
									res_val_q  <= cap_q;
									state_q    <= ST_EMIT;
								end
								default: begin
								end
							endcase
						end
					end
				end
				ST_SHIFT: begin
					if (cnt_q != '0) begin
						waddr_s1 <= dst_q;
						cnt_q    <= cnt_q - AW'(1);
						src_q    <= up_q ? src_q + AW'(1) : src_q - AW'(1);
						dst_q    <= up_q ? dst_q + AW'(1) : dst_q - AW'(1);
					end else if (shift_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_kind_q  <= res_kind_q;
						out_value_q <= (res_kind_q == gaie_pkg::KIND_ELEMENT)
						               ? rd_data_q : gaie_pkg::VALUE_W'(res_val_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_kind  = out_kind_q;
	assign rsp.result_value = out_value_q;

	// The size stays below the store depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(fill_q) < CW'(DEPTH))
		else $error("size reached the store depth");

	// The capacity is a power of two above the size.
	a_cap_shape: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(cap_q) && (cap_q > CW'(fill_q)))
		else $error("capacity is not a power of two above the size");

	// Delayed shift writes only occur while the sequencer is moving entries.
	a_wpend_shift: assert property (@(posedge clk) disable iff (!arst_n)
		wpend_s1 |-> (state_q == ST_SHIFT))
		else $error("shift write outside a shift");

	// A result is only loaded when the output register is free or being drained.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> (out_valid_q && $stable(out_value_q)))
		else $error("pending result was overwritten");

endmodule
